/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL, empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion, disabled while reset is active
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/core/erc_pkg.sv */
// ---------------------------------------------------------------------------
// erc_pkg
// Shared types and constants of the receive frame classifier.
// ---------------------------------------------------------------------------
package erc_pkg;

    localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
    localparam logic [15:0] ARP_MIN_BYTES = 16'd42;
    localparam logic [15:0] IPV4_MIN_BYTES = 16'd34;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP = 16'h0806;
    localparam logic [3:0] IP_VERSION_4 = 4'd4;
    localparam logic [3:0] IHL_MIN = 4'd5;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [31:0] IP_BROADCAST = 32'hFFFF_FFFF;
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_LOCAL_IP = 1'b0;
    localparam logic CFG_LOCAL_IP_VALID = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_DROP = 3'd0,
        VERDICT_ARP  = 3'd1,
        VERDICT_ICMP = 3'd2,
        VERDICT_TCP  = 3'd3,
        VERDICT_UDP  = 3'd4
    } t_verdict;

    // header fields captured while a frame streams in
    typedef struct packed {
        logic [15:0] frame_type;
        logic [7:0]  ver_ihl;
        logic [15:0] total_len;
        logic [7:0]  protocol;
        logic [31:0] dest_addr;
    } t_hdr;

    // a finished frame waiting for its verdict
    typedef struct packed {
        logic        valid;
        t_hdr        hdr;
        logic [15:0] len;
    } t_frame;

endpackage

/* rtl/core/erc_capture.sv */
// ---------------------------------------------------------------------------
// erc_capture
// Byte counter and header field capture; hands each finished frame to the
// verdict stage through a one-entry frame register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module erc_capture (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last,
    input  logic              i_take,
    output erc_pkg::t_frame   o_frame
);

    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] POS_VER_IHL  = 16'd14;
    localparam logic [15:0] POS_TLEN_HI  = 16'd16;
    localparam logic [15:0] POS_TLEN_LO  = 16'd17;
    localparam logic [15:0] POS_PROTO    = 16'd23;
    localparam logic [15:0] POS_DEST_0   = 16'd30;
    localparam logic [15:0] POS_DEST_1   = 16'd31;
    localparam logic [15:0] POS_DEST_2   = 16'd32;
    localparam logic [15:0] POS_DEST_3   = 16'd33;

    logic [15:0]     r_pos;
    erc_pkg::t_hdr   r_hdr;
    erc_pkg::t_frame r_frame;
    erc_pkg::t_hdr   n_hdr;
    logic [15:0]     n_pos;
    logic            accept;

    // hold input only while a finished frame cannot move on
    assign o_in_stall = r_frame.valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_pos      = (r_pos != erc_pkg::POS_MAX) ? r_pos + 16'd1 : erc_pkg::POS_MAX;

    always_comb begin
        n_hdr = r_hdr;
        unique case (r_pos)
            POS_ETYPE_HI: n_hdr.frame_type[15:8] = i_data_byte;
            POS_ETYPE_LO: n_hdr.frame_type[7:0]  = i_data_byte;
            POS_VER_IHL:  n_hdr.ver_ihl          = i_data_byte;
            POS_TLEN_HI:  n_hdr.total_len[15:8]  = i_data_byte;
            POS_TLEN_LO:  n_hdr.total_len[7:0]   = i_data_byte;
            POS_PROTO:    n_hdr.protocol         = i_data_byte;
            POS_DEST_0:   n_hdr.dest_addr[31:24] = i_data_byte;
            POS_DEST_1:   n_hdr.dest_addr[23:16] = i_data_byte;
            POS_DEST_2:   n_hdr.dest_addr[15:8]  = i_data_byte;
            POS_DEST_3:   n_hdr.dest_addr[7:0]   = i_data_byte;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_hdr         <= '0;
            r_frame.valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last) begin
                    // clear for the next frame
                    r_pos <= '0;
                    r_hdr <= '0;
                end else begin
                    r_pos <= n_pos;
                    r_hdr <= n_hdr;
                end
            end
            if (accept && i_last) begin
                r_frame.valid <= 1'b1;
            end else if (i_take) begin
                r_frame.valid <= 1'b0;
            end
        end
        if (accept && i_last) begin
            r_frame.hdr <= n_hdr;
            r_frame.len <= n_pos;
        end
    end

    assign o_frame = r_frame;

    `ASSERT_CLK(a_clear_after_last, i_clk, i_rst_n, (accept && i_last) |=> (r_pos == '0))
    `ASSERT_CLK(a_frame_held, i_clk, i_rst_n,
        (r_frame.valid && !i_take) |=> (r_frame.valid && $stable(r_frame.len)))

endmodule

/* rtl/core/erc_judge.sv */
// ---------------------------------------------------------------------------
// erc_judge
// Configuration registers, frame classification and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module erc_judge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  erc_pkg::t_frame   i_frame,
    output logic              o_take,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_verdict,
    output logic [5:0]        o_ip_header_bytes,
    output logic [15:0]       o_ip_total_bytes,
    output logic [15:0]       o_frame_bytes
);

    logic [31:0]       r_local_ip;
    logic              r_local_ip_valid;
    logic              r_out_valid;
    erc_pkg::t_verdict r_verdict;
    logic [5:0]        r_hdr_bytes;
    logic [15:0]       r_tot_bytes;
    logic [15:0]       r_len;

    erc_pkg::t_verdict n_verdict;
    logic [5:0]        n_hdr_bytes;
    logic [15:0]       n_tot_bytes;
    logic [3:0]        ver;
    logic [3:0]        ihl;
    logic [5:0]        hdr;
    logic [15:0]       len;
    logic [15:0]       tot;
    logic              ours;
    logic              hdr_ok;
    logic              load;

    assign len  = i_frame.len;
    assign tot  = i_frame.hdr.total_len;
    assign ver  = i_frame.hdr.ver_ihl[7:4];
    assign ihl  = i_frame.hdr.ver_ihl[3:0];
    assign hdr  = {ihl, 2'b00};
    assign ours = r_local_ip_valid && (i_frame.hdr.dest_addr == r_local_ip);

    // IPv4 header sanity; len is at least the IPv4 minimum wherever this is used
    assign hdr_ok = (ver == erc_pkg::IP_VERSION_4) && (ihl >= erc_pkg::IHL_MIN)
        && (len >= erc_pkg::ETH_HDR_BYTES + {10'd0, hdr})
        && (tot >= {10'd0, hdr}) && (tot <= len - erc_pkg::ETH_HDR_BYTES);

    always_comb begin
        n_verdict = erc_pkg::VERDICT_DROP;
        priority if (len < erc_pkg::ETH_HDR_BYTES) begin
            n_verdict = erc_pkg::VERDICT_DROP;
        end else if (i_frame.hdr.frame_type == erc_pkg::ETYPE_ARP) begin
            if (len >= erc_pkg::ARP_MIN_BYTES) begin
                n_verdict = erc_pkg::VERDICT_ARP;
            end
        end else if (i_frame.hdr.frame_type != erc_pkg::ETYPE_IPV4
                     || len < erc_pkg::IPV4_MIN_BYTES || !hdr_ok) begin
            n_verdict = erc_pkg::VERDICT_DROP;
        end else if (i_frame.hdr.protocol == erc_pkg::PROTO_ICMP) begin
            if (ours) begin
                n_verdict = erc_pkg::VERDICT_ICMP;
            end
        end else if (i_frame.hdr.protocol == erc_pkg::PROTO_TCP) begin
            if (ours) begin
                n_verdict = erc_pkg::VERDICT_TCP;
            end
        end else if (i_frame.hdr.protocol == erc_pkg::PROTO_UDP) begin
            if (ours || i_frame.hdr.dest_addr == erc_pkg::IP_BROADCAST) begin
                n_verdict = erc_pkg::VERDICT_UDP;
            end
        end else begin
            n_verdict = erc_pkg::VERDICT_DROP;
        end
    end

    // lengths are reported for IP verdicts only
    always_comb begin
        n_hdr_bytes = '0;
        n_tot_bytes = '0;
        if (n_verdict == erc_pkg::VERDICT_ICMP || n_verdict == erc_pkg::VERDICT_TCP
            || n_verdict == erc_pkg::VERDICT_UDP) begin
            n_hdr_bytes = hdr;
            n_tot_bytes = tot;
        end
    end

    assign o_take = !r_out_valid || !i_out_stall;
    assign load   = i_frame.valid && o_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip       <= '0;
            r_local_ip_valid <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    erc_pkg::CFG_LOCAL_IP:       r_local_ip       <= i_cfg_data;
                    erc_pkg::CFG_LOCAL_IP_VALID: r_local_ip_valid <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_verdict   <= n_verdict;
            r_hdr_bytes <= n_hdr_bytes;
            r_tot_bytes <= n_tot_bytes;
            r_len       <= len;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_verdict         = r_verdict;
    assign o_ip_header_bytes = r_hdr_bytes;
    assign o_ip_total_bytes  = r_tot_bytes;
    assign o_frame_bytes     = r_len;

    `ASSERT_CLK(a_drop_no_lengths, i_clk, i_rst_n,
        (r_out_valid && (r_verdict == erc_pkg::VERDICT_DROP || r_verdict == erc_pkg::VERDICT_ARP))
        |-> (r_hdr_bytes == '0 && r_tot_bytes == '0))
    `ASSERT_CLK(a_ip_hdr_min, i_clk, i_rst_n,
        (r_out_valid && (r_verdict == erc_pkg::VERDICT_ICMP || r_verdict == erc_pkg::VERDICT_TCP
        || r_verdict == erc_pkg::VERDICT_UDP)) |-> (r_hdr_bytes >= 6'd20 && r_len >= 16'd34))
    `ASSERT_CLK(a_result_kept, i_clk, i_rst_n,
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_verdict)))

endmodule

/* rtl/core/eth_ipv4_rx_classifier.sv */
// ---------------------------------------------------------------------------
// eth_ipv4_rx_classifier
// Byte-stream Ethernet receive classifier for ARP and IPv4 ICMP/TCP/UDP.
// ---------------------------------------------------------------------------
// Takes one frame byte per cycle while o_in_stall is low, starting at the
// destination MAC, with i_last on the final byte, and gives one result per
// frame: verdict (drop, ARP, ICMP, TCP, UDP), IPv4 header and total lengths,
// and the saturating frame length. The frame register loads on the edge
// that transfers the last byte; the result register loads from it once no
// stalled result is waiting in it. Input is stalled only while a finished
// frame and a stalled result both wait. Write local_ip (index 0) and
// local_ip_valid (index 1) while no frame is in flight.
module eth_ipv4_rx_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_verdict,
    output logic [5:0]  o_ip_header_bytes,
    output logic [15:0] o_ip_total_bytes,
    output logic [15:0] o_frame_bytes
);

    erc_pkg::t_frame frame;
    logic            take;

    erc_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_take      (take),
        .o_frame     (frame)
    );

    erc_judge u_judge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_frame           (frame),
        .o_take            (take),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_verdict         (o_verdict),
        .o_ip_header_bytes (o_ip_header_bytes),
        .o_ip_total_bytes  (o_ip_total_bytes),
        .o_frame_bytes     (o_frame_bytes)
    );

endmodule

/* tb/tb_eth_ipv4_rx_classifier.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_eth_ipv4_rx_classifier
// Streams Ethernet frames byte by byte into the receive classifier and
// checks every verdict against the directed table's expected values or a
// local classifier model. A directed table covers the length, version, IHL
// and address corners. Random frames follow, mostly well-formed IPv4 with
// random content, under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
module tb_eth_ipv4_rx_classifier;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD    = 300;
    localparam int RAND_BYTES   = 100;
    localparam int RAND_FRAMES  = 3;

    // byte offsets of the captured header fields
    localparam int POS_ETYPE   = 12;
    localparam int POS_VER_IHL = 14;
    localparam int POS_TOTAL   = 16;
    localparam int POS_PROTO   = 23;
    localparam int POS_DEST    = 30;

    localparam logic [15:0] ETYPE_OTHER = 16'h86DD;
    localparam logic [31:0] HOST_A      = 32'hC0A8_0105;
    localparam logic [31:0] HOST_B      = 32'hC0A8_0106;

    typedef struct {
        erc_pkg::t_verdict verdict;
        logic [5:0]        hdr_bytes;
        logic [15:0]       total_bytes;
        logic [15:0]       frame_bytes;
    } t_verdict_rec;

    typedef struct {
        int                len;
        logic [15:0]       etype;
        logic [7:0]        ver_ihl;
        logic [15:0]       total_len;
        logic [7:0]        protocol;
        logic [31:0]       dest;
        bit                set_cfg;
        logic [31:0]       cfg_ip;
        bit                cfg_ip_ok;
        bit                typed;
        erc_pkg::t_verdict verdict;
        logic [5:0]        hdr_bytes;
        logic [15:0]       total_bytes;
        logic [15:0]       frame_bytes;
    } t_frame_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = erc_pkg::CFG_LOCAL_IP;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_verdict;
    logic [5:0]  o_ip_header_bytes;
    logic [15:0] o_ip_total_bytes;
    logic [15:0] o_frame_bytes;

    // classifier model state
    logic [31:0] own_ip;
    logic        own_ip_ok;
    logic [15:0] rx_pos;
    logic [15:0] rx_etype;
    logic [7:0]  rx_vihl;
    logic [15:0] rx_tot;
    logic [7:0]  rx_proto;
    logic [31:0] rx_dest;

    t_verdict_rec verdict_q [$];
    int errors = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;
    int quiet = 0;

    t_frame_row dir_rows [22] = '{
        // len, etype, ver_ihl, total, proto, dest, cfg, ip, ok, typed, verdict, hdr, tot, len
        '{1, erc_pkg::ETYPE_IPV4, 8'h45, 0, 0, 0, 0, 0, 0,
          1, erc_pkg::VERDICT_DROP, 0, 0, 1},
        '{13, erc_pkg::ETYPE_IPV4, 8'h45, 46, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 13},
        '{14, erc_pkg::ETYPE_ARP, 0, 0, 0, 0, 0, 0, 0,
          1, erc_pkg::VERDICT_DROP, 0, 0, 14},
        '{41, erc_pkg::ETYPE_ARP, 0, 0, 0, 0, 0, 0, 0,
          1, erc_pkg::VERDICT_DROP, 0, 0, 41},
        '{42, erc_pkg::ETYPE_ARP, 0, 0, 0, 0, 0, 0, 0,
          1, erc_pkg::VERDICT_ARP, 0, 0, 42},
        '{60, ETYPE_OTHER, 8'h45, 46, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{33, erc_pkg::ETYPE_IPV4, 8'h45, 19, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 33},
        '{60, erc_pkg::ETYPE_IPV4, 8'h65, 46, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h44, 46, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h4F, 46, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 19, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 47, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 16'hFFFF, erc_pkg::PROTO_UDP,
          erc_pkg::IP_BROADCAST, 0, 0, 0, 1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        // destination equals the reset address, but no address is set yet
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 46, erc_pkg::PROTO_TCP, 0, 0, 0, 0,
          1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 46, erc_pkg::PROTO_UDP, erc_pkg::IP_BROADCAST,
          0, 0, 0, 1, erc_pkg::VERDICT_UDP, 20, 46, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 46, erc_pkg::PROTO_ICMP, HOST_A, 1, HOST_A, 1,
          1, erc_pkg::VERDICT_ICMP, 20, 46, 60},
        '{54, erc_pkg::ETYPE_IPV4, 8'h45, 40, erc_pkg::PROTO_TCP, HOST_A, 0, 0, 0,
          0, erc_pkg::VERDICT_DROP, 0, 0, 0},
        '{74, erc_pkg::ETYPE_IPV4, 8'h4F, 60, erc_pkg::PROTO_UDP, HOST_A, 0, 0, 0,
          0, erc_pkg::VERDICT_DROP, 0, 0, 0},
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 46, erc_pkg::PROTO_TCP, HOST_B, 0, 0, 0,
          1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 46, 8'hFF, HOST_A, 0, 0, 0,
          1, erc_pkg::VERDICT_DROP, 0, 0, 60},
        '{60, erc_pkg::ETYPE_IPV4, 8'h45, 20, erc_pkg::PROTO_TCP, erc_pkg::IP_BROADCAST,
          1, erc_pkg::IP_BROADCAST, 1, 0, erc_pkg::VERDICT_DROP, 0, 0, 0},
        '{34, erc_pkg::ETYPE_IPV4, 8'h45, 20, erc_pkg::PROTO_ICMP, 0, 1, 0, 1,
          0, erc_pkg::VERDICT_DROP, 0, 0, 0}
    };

    eth_ipv4_rx_classifier dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_last            (i_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_verdict         (o_verdict),
        .o_ip_header_bytes (o_ip_header_bytes),
        .o_ip_total_bytes  (o_ip_total_bytes),
        .o_frame_bytes     (o_frame_bytes)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_rx();
        rx_pos = '0;
        rx_etype = '0;
        rx_vihl = '0;
        rx_tot = '0;
        rx_proto = '0;
        rx_dest = '0;
    endfunction

    function automatic t_verdict_rec judge_frame(logic [15:0] len);
        t_verdict_rec r;
        int hdr;
        int l;
        bit ours;
        r.verdict = erc_pkg::VERDICT_DROP;
        r.hdr_bytes = '0;
        r.total_bytes = '0;
        r.frame_bytes = len;
        l = len;
        hdr = 4 * int'(rx_vihl[3:0]);
        ours = own_ip_ok && (rx_dest == own_ip);
        if (l < erc_pkg::ETH_HDR_BYTES)
            return r;
        if (rx_etype == erc_pkg::ETYPE_ARP) begin
            if (l >= erc_pkg::ARP_MIN_BYTES)
                r.verdict = erc_pkg::VERDICT_ARP;
            return r;
        end
        if (rx_etype != erc_pkg::ETYPE_IPV4 || l < erc_pkg::IPV4_MIN_BYTES)
            return r;
        if (rx_vihl[7:4] != erc_pkg::IP_VERSION_4 || rx_vihl[3:0] < erc_pkg::IHL_MIN)
            return r;
        if (l < int'(erc_pkg::ETH_HDR_BYTES) + hdr)
            return r;
        if (int'(rx_tot) < hdr || int'(rx_tot) > l - int'(erc_pkg::ETH_HDR_BYTES))
            return r;
        if (rx_proto == erc_pkg::PROTO_ICMP && ours)
            r.verdict = erc_pkg::VERDICT_ICMP;
        else if (rx_proto == erc_pkg::PROTO_TCP && ours)
            r.verdict = erc_pkg::VERDICT_TCP;
        else if (rx_proto == erc_pkg::PROTO_UDP && (ours || rx_dest == erc_pkg::IP_BROADCAST))
            r.verdict = erc_pkg::VERDICT_UDP;
        else
            return r;
        r.hdr_bytes = hdr[5:0];
        r.total_bytes = rx_tot;
        return r;
    endfunction

    // advance the model by one byte; returns one when the frame ends
    function automatic bit classify_byte(logic [7:0] b, bit l, output t_verdict_rec r);
        logic [15:0] len;
        case (rx_pos)
            POS_ETYPE:       rx_etype[15:8] = b;
            POS_ETYPE + 1:   rx_etype[7:0] = b;
            POS_VER_IHL:     rx_vihl = b;
            POS_TOTAL:       rx_tot[15:8] = b;
            POS_TOTAL + 1:   rx_tot[7:0] = b;
            POS_PROTO:       rx_proto = b;
            POS_DEST:        rx_dest[31:24] = b;
            POS_DEST + 1:    rx_dest[23:16] = b;
            POS_DEST + 2:    rx_dest[15:8] = b;
            POS_DEST + 3:    rx_dest[7:0] = b;
            default: ;
        endcase
        len = (rx_pos == erc_pkg::POS_MAX) ? erc_pkg::POS_MAX : rx_pos + 16'd1;
        rx_pos = len;
        r = '{erc_pkg::VERDICT_DROP, '0, '0, '0};
        if (!l)
            return 1'b0;
        r = judge_frame(len);
        clear_rx();
        return 1'b1;
    endfunction

    function automatic logic [7:0] frame_byte(int p, t_frame_row f);
        case (p)
            POS_ETYPE:     return f.etype[15:8];
            POS_ETYPE + 1: return f.etype[7:0];
            POS_VER_IHL:   return f.ver_ihl;
            POS_TOTAL:     return f.total_len[15:8];
            POS_TOTAL + 1: return f.total_len[7:0];
            POS_PROTO:     return f.protocol;
            POS_DEST:      return f.dest[31:24];
            POS_DEST + 1:  return f.dest[23:16];
            POS_DEST + 2:  return f.dest[15:8];
            POS_DEST + 3:  return f.dest[7:0];
            default:       return 8'($urandom);
        endcase
    endfunction

    function automatic t_frame_row make_random_frame();
        t_frame_row f;
        int k;
        int ihl;
        int hdr;
        int pick;
        f.set_cfg = 1'b0;
        f.cfg_ip = '0;
        f.cfg_ip_ok = 1'b0;
        f.typed = 1'b0;
        f.verdict = erc_pkg::VERDICT_DROP;
        f.hdr_bytes = '0;
        f.total_bytes = '0;
        f.frame_bytes = '0;
        f.etype = erc_pkg::ETYPE_IPV4;
        f.ver_ihl = 8'($urandom);
        f.total_len = 16'($urandom);
        f.protocol = 8'($urandom);
        f.dest = $urandom;
        k = $urandom_range(99);
        if (k < 65) begin
            ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
            hdr = 4 * ihl;
            f.len = erc_pkg::ETH_HDR_BYTES + hdr + $urandom_range(40);
            f.ver_ihl = {erc_pkg::IP_VERSION_4, 4'(ihl)};
            if ($urandom_range(19) == 0)
                f.ver_ihl[7:4] = 4'($urandom);
            pick = $urandom_range(9);
            if (pick == 0)
                f.total_len = 16'(hdr - 1);
            else if (pick == 1)
                f.total_len = 16'(f.len - erc_pkg::ETH_HDR_BYTES + 1);
            else
                f.total_len = 16'($urandom_range(f.len - erc_pkg::ETH_HDR_BYTES, hdr));
            case ($urandom_range(3))
                0: f.protocol = erc_pkg::PROTO_ICMP;
                1: f.protocol = erc_pkg::PROTO_TCP;
                2: f.protocol = erc_pkg::PROTO_UDP;
                default: ;
            endcase
            case ($urandom_range(4))
                0, 1: f.dest = own_ip;
                2:    f.dest = erc_pkg::IP_BROADCAST;
                3:    f.dest = own_ip ^ (32'd1 << $urandom_range(31));
                default: ;
            endcase
        end else if (k < 75) begin
            f.etype = erc_pkg::ETYPE_ARP;
            f.len = $urandom_range(50, 38);
        end else if (k < 85) begin
            // short or truncated frames
            f.len = $urandom_range(40, 1);
            pick = $urandom_range(2);
            if (pick == 1)
                f.etype = erc_pkg::ETYPE_ARP;
            else if (pick == 2)
                f.etype = 16'($urandom);
        end else begin
            f.len = $urandom_range(80, 14);
            if ($urandom_range(1) == 1)
                f.etype = 16'($urandom);
        end
        return f;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    task automatic send_byte(logic [7:0] b, bit l, bit typed, t_verdict_rec want);
        t_verdict_rec predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_last <= l;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (classify_byte(b, l, predicted))
            verdict_q.push_back(typed ? want : predicted);
    endtask

    task automatic send_frame(t_frame_row f);
        t_verdict_rec want;
        want = '{f.verdict, f.hdr_bytes, f.total_bytes, f.frame_bytes};
        for (int p = 0; p < f.len; p++)
            send_byte(frame_byte(p, f), p == f.len - 1, f.typed, want);
    endtask

    // hold the input until every pending verdict has been transferred
    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [31:0] ip, bit ok);
        logic [31:0] valid_word;
        go_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        valid_word = $urandom;
        valid_word[0] = ok;
        i_cfg_we <= 1'b1;
        i_cfg_index <= erc_pkg::CFG_LOCAL_IP;
        i_cfg_data <= ip;
        @(posedge i_clk);
        i_cfg_index <= erc_pkg::CFG_LOCAL_IP_VALID;
        i_cfg_data <= valid_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        own_ip = ip;
        own_ip_ok = ok;
    endtask

    always @(posedge i_clk) begin : result_side
        t_verdict_rec want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got verdict %0d len %0d",
                             $time, o_verdict, o_frame_bytes);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("verdict", want.verdict, o_verdict);
                    check_field("ip_header_bytes", want.hdr_bytes, o_ip_header_bytes);
                    check_field("ip_total_bytes", want.total_bytes, o_ip_total_bytes);
                    check_field("frame_bytes", want.frame_bytes, o_frame_bytes);
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
        if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < snk_stall_pct);
        end
    end

    initial begin : stimulus
        t_frame_row f;
        int nbytes;
        int nframes;
        own_ip = '0;
        own_ip_ok = 1'b0;
        clear_rx();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_cfg)
                write_cfg(dir_rows[i].cfg_ip, dir_rows[i].cfg_ip_ok);
            send_frame(dir_rows[i]);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_cfg($urandom, 1'b1);
                1: write_cfg(erc_pkg::IP_BROADCAST, 1'b1);
                2: write_cfg(32'h0, 1'b1);
                default: write_cfg($urandom, 1'b0);
            endcase
            case (ph)
                0: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                    // long receiver hold while frames keep coming
                    hold_asks++;
                end
                1: begin
                    src_idle_pct = 83;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 83;
                end
                default: begin
                    src_idle_pct = 15;
                    snk_stall_pct = 15;
                end
            endcase
            nbytes = 0;
            nframes = 0;
            while (nbytes < RAND_BYTES || nframes < RAND_FRAMES) begin
                f = make_random_frame();
                send_frame(f);
                nbytes += f.len;
                nframes++;
            end
        end

        go_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
